>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by ttph_in_stage and ttph_parse.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/ttph_pkg.sv
// ----------------------------------------------------------------------------
// ttph_pkg
// Types and constants for the TinyTP PDU header parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttph_pkg;

  localparam int unsigned VALUE_BYTES = 4;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [7:0] CREDIT_MASK     = 8'h7f;
  localparam logic [7:0] RST_LIST_LIMIT  = 8'd60;
  localparam logic [7:0] RST_TARGET_ID   = 8'h01;
  localparam logic       FUNC_CONNECT    = 1'b0;

  localparam logic [CFG_IDX_W-1:0] CFG_PARAM_LIST_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PARAM_ID  = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_PLEN   = 3'd1,
    PH_PI     = 3'd2,
    PH_PL     = 3'd3,
    PH_VALUE  = 3'd4,
    PH_USER   = 3'd5
  } phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] pdu_byte;
    logic       pdu_last;
  } item_t;

  typedef struct packed {
    logic        header_valid;
    logic        flag_bit;
    logic [6:0]  credit_value;
    logic [7:0]  user_byte;
    logic        user_valid;
    logic        sdu_found;
    logic [31:0] max_sdu;
    logic        param_error;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/tinytp_pdu_header_parser_core.sv
// A word accepted at the input handshake is held in the input register, then moves
// to the result register when that register is free; out_valid rises once it is there.
// Throughput: one word per cycle while out_ready stays high; the parse state
// updates as each word moves from the input register to the result register.
// Reset (rst_n low, synchronous): both registers empty, parser in header
// phase, param_list_limit = 60, target_param_id = 1.
// ----------------------------------------------------------------------------
// tinytp_pdu_header_parser_core
// TinyTP PDU header and max SDU size parameter parser, one byte per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tinytp_pdu_header_parser_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [ttph_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ttph_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_func,
  input  wire logic [7:0]                      in_pdu_byte,
  input  wire logic                            in_pdu_last,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_header_valid,
  output logic                                 out_flag_bit,
  output logic [6:0]                           out_credit_value,
  output logic [7:0]                           out_user_byte,
  output logic                                 out_user_valid,
  output logic                                 out_sdu_found,
  output logic [31:0]                          out_max_sdu,
  output logic                                 out_param_error,
  output logic                                 out_last
);

  ttph_pkg::item_t   in_item;
  ttph_pkg::item_t   held_item;
  ttph_pkg::result_t parse_res;
  ttph_pkg::result_t res_q;
  logic              held_vld;
  logic              take;
  logic              adv;

  assign in_item.func     = in_func;
  assign in_item.pdu_byte = in_pdu_byte;
  assign in_item.pdu_last = in_pdu_last;

  assign adv = held_vld && take;

  ttph_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .vld      (held_vld),
    .item     (held_item)
  );

  ttph_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .adv       (adv),
    .item      (held_item),
    .result    (parse_res)
  );

  ttph_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (held_vld),
    .res_in    (parse_res),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign out_header_valid = res_q.header_valid;
  assign out_flag_bit     = res_q.flag_bit;
  assign out_credit_value = res_q.credit_value;
  assign out_user_byte    = res_q.user_byte;
  assign out_user_valid   = res_q.user_valid;
  assign out_sdu_found    = res_q.sdu_found;
  assign out_max_sdu      = res_q.max_sdu;
  assign out_param_error  = res_q.param_error;
  assign out_last         = res_q.last;

endmodule

`default_nettype wire

>>> hw/rtl/ttph_in_stage.sv
// ----------------------------------------------------------------------------
// ttph_in_stage
// Input register: holds one accepted word until the parser takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ttph_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ttph_pkg::item_t in_item,
  input  wire logic            take,      // downstream can absorb the held word
  output logic                 vld,
  output ttph_pkg::item_t      item
);

  logic            vld_r;
  ttph_pkg::item_t item_r;

  assign in_ready = !vld_r || take;
  assign vld      = vld_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  `ASSERT_IMP(a_empty_ready, clk, rst_n, !vld_r, in_ready)

endmodule

`default_nettype wire

>>> hw/rtl/ttph_parse.sv
// ----------------------------------------------------------------------------
// ttph_parse
// Per-PDU parse state, config registers and the one-word update logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ttph_parse (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [ttph_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ttph_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                                adv,
  input  wire ttph_pkg::item_t                     item,
  output ttph_pkg::result_t                        result
);

  logic [7:0]       list_limit_r;
  logic [7:0]       target_id_r;

  ttph_pkg::phase_t phase_r, phase_nxt, phase_step;
  logic [7:0]       param_left_r, param_left_nxt;
  logic [7:0]       value_left_r, value_left_nxt;
  logic             is_target_r, is_target_nxt;
  logic [31:0]      accum_r, accum_nxt;
  logic             found_r, found_nxt;
  logic             error_r, error_nxt;

  logic [7:0]       b;
  logic [7:0]       pl_dec;
  logic [7:0]       vl_dec;
  logic             hdr_flag;

  assign b        = item.pdu_byte;
  assign pl_dec   = param_left_r - 8'd1;
  assign vl_dec   = value_left_r - 8'd1;
  assign hdr_flag = b[7];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_limit_r <= ttph_pkg::RST_LIST_LIMIT;
      target_id_r  <= ttph_pkg::RST_TARGET_ID;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ttph_pkg::CFG_PARAM_LIST_LIMIT: list_limit_r <= cfg_wdata;
        ttph_pkg::CFG_TARGET_PARAM_ID:  target_id_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_step = phase_r;
    unique case (phase_r)
      ttph_pkg::PH_HEADER: begin
        phase_step = (item.func == ttph_pkg::FUNC_CONNECT && hdr_flag) ?
                     ttph_pkg::PH_PLEN : ttph_pkg::PH_USER;
      end
      ttph_pkg::PH_PLEN: begin
        phase_step = (b > list_limit_r || b == 8'd0) ? ttph_pkg::PH_USER : ttph_pkg::PH_PI;
      end
      ttph_pkg::PH_PI: begin
        phase_step = (pl_dec == 8'd0) ? ttph_pkg::PH_USER : ttph_pkg::PH_PL;
      end
      ttph_pkg::PH_PL: begin
        if (pl_dec == 8'd0) phase_step = ttph_pkg::PH_USER;
        else if (b == 8'd0) phase_step = ttph_pkg::PH_PI;
        else                phase_step = ttph_pkg::PH_VALUE;
      end
      ttph_pkg::PH_VALUE: begin
        if (pl_dec == 8'd0)      phase_step = ttph_pkg::PH_USER;
        else if (vl_dec == 8'd0) phase_step = ttph_pkg::PH_PI;
        else                     phase_step = ttph_pkg::PH_VALUE;
      end
      default: phase_step = ttph_pkg::PH_USER;
    endcase
    phase_nxt = item.pdu_last ? ttph_pkg::PH_HEADER : phase_step;
  end

  // datapath and result
  always_comb begin
    param_left_nxt = param_left_r;
    value_left_nxt = value_left_r;
    is_target_nxt  = is_target_r;
    accum_nxt      = accum_r;
    found_nxt      = found_r;
    error_nxt      = error_r;
    result         = '0;

    unique case (phase_r)
      ttph_pkg::PH_HEADER: begin
        result.header_valid = 1'b1;
        result.flag_bit     = hdr_flag;
        result.credit_value = 7'(b & ttph_pkg::CREDIT_MASK);
        found_nxt      = 1'b0;
        error_nxt      = 1'b0;
        accum_nxt      = '0;
        is_target_nxt  = 1'b0;
        param_left_nxt = '0;
        value_left_nxt = '0;
      end
      ttph_pkg::PH_PLEN: begin
        if (b > list_limit_r) error_nxt = 1'b1;
        else if (b != 8'd0)   param_left_nxt = b;
      end
      ttph_pkg::PH_PI: begin
        param_left_nxt = pl_dec;
        is_target_nxt  = (b == target_id_r) && !found_r && !error_r && (pl_dec != 8'd0);
      end
      ttph_pkg::PH_PL: begin
        param_left_nxt = pl_dec;
        value_left_nxt = b;
        if (is_target_r) begin
          if (b > 8'(ttph_pkg::VALUE_BYTES)) begin
            error_nxt     = 1'b1;
            is_target_nxt = 1'b0;
          end else begin
            accum_nxt = '0;
            // empty value or list ends here: found with value zero
            if (b == 8'd0 || pl_dec == 8'd0) begin
              found_nxt     = 1'b1;
              is_target_nxt = 1'b0;
            end
          end
        end
      end
      ttph_pkg::PH_VALUE: begin
        param_left_nxt = pl_dec;
        value_left_nxt = vl_dec;
        if (is_target_r) begin
          accum_nxt = {accum_r[23:0], b};
          if (vl_dec == 8'd0 || pl_dec == 8'd0) begin
            found_nxt     = 1'b1;
            is_target_nxt = 1'b0;
          end
        end
      end
      default: begin
        result.user_valid = 1'b1;
        result.user_byte  = b;
      end
    endcase

    result.sdu_found   = found_nxt;
    result.max_sdu     = found_nxt ? accum_nxt : 32'd0;
    result.param_error = error_nxt;
    result.last        = item.pdu_last;

    if (item.pdu_last) begin
      is_target_nxt  = 1'b0;
      param_left_nxt = '0;
      value_left_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ttph_pkg::PH_HEADER;
      param_left_r <= '0;
      value_left_r <= '0;
      is_target_r  <= 1'b0;
      accum_r      <= '0;
      found_r      <= 1'b0;
      error_r      <= 1'b0;
    end else if (adv) begin
      phase_r      <= phase_nxt;
      param_left_r <= param_left_nxt;
      value_left_r <= value_left_nxt;
      is_target_r  <= is_target_nxt;
      accum_r      <= accum_nxt;
      found_r      <= found_nxt;
      error_r      <= error_nxt;
    end
  end

  `ASSERT_NXT(a_last_to_header, clk, rst_n, adv && item.pdu_last,
              phase_r == ttph_pkg::PH_HEADER)
  `ASSERT_IMP(a_sdu_needs_found, clk, rst_n, result.max_sdu != 32'd0, result.sdu_found)
  `ASSERT_IMP(a_target_in_list, clk, rst_n, is_target_r,
              phase_r == ttph_pkg::PH_PL || phase_r == ttph_pkg::PH_VALUE)

endmodule

`default_nettype wire

>>> hw/rtl/ttph_out_stage.sv
// ----------------------------------------------------------------------------
// ttph_out_stage
// Result register with valid/ready toward the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttph_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,     // a parsed word arrives
  input  wire ttph_pkg::result_t res_in,
  output logic                   take,     // register free this cycle
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ttph_pkg::result_t      res_out
);

  logic              vld_r;
  ttph_pkg::result_t res_r;

  assign take      = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (take && load) begin
      res_r <= res_in;
    end
  end

endmodule

`default_nettype wire
